// ===== sv/sma_pkg.sv =====
// ============================================================================
// sma_pkg
// Shared types, opcodes and trap codes for the evaluation stack ALU.
// ============================================================================
package sma_pkg;

  localparam int unsigned StackDepthDefault = 14;

  typedef enum logic [5:0] {
    OP_REC = 6'd0, OP_REC2 = 6'd1, OP_DIS = 6'd2, OP_DIS2 = 6'd3,
    OP_EXCH = 6'd4, OP_DEXCH = 6'd5, OP_DUP = 6'd6, OP_DDUP = 6'd7,
    OP_EXDIS = 6'd8, OP_BNDCK = 6'd9, OP_BNDCKL = 6'd10, OP_NILCK = 6'd11,
    OP_NILCKL = 6'd12, OP_NEG = 6'd13, OP_INC = 6'd14, OP_DINC = 6'd15,
    OP_DEC = 6'd16, OP_ADDSB = 6'd17, OP_DBL = 6'd18, OP_DDBL = 6'd19,
    OP_TRPL = 6'd20, OP_LINT = 6'd21, OP_SHIFTSB = 6'd22, OP_AND = 6'd23,
    OP_DAND = 6'd24, OP_IOR = 6'd25, OP_DIOR = 6'd26, OP_XOR = 6'd27,
    OP_DXOR = 6'd28, OP_SHIFT = 6'd29, OP_DSHIFT = 6'd30, OP_ROTATE = 6'd31,
    OP_ADD = 6'd32, OP_SUB = 6'd33, OP_DADD = 6'd34, OP_DSUB = 6'd35,
    OP_ADC = 6'd36, OP_ACD = 6'd37, OP_MUL = 6'd38, OP_DMUL = 6'd39,
    OP_SDIV = 6'd40, OP_UDIV = 6'd41, OP_LUDIV = 6'd42, OP_SDDIV = 6'd43,
    OP_UDDIV = 6'd44, OP_DCMP = 6'd45, OP_UDCMP = 6'd46, OP_PUSH = 6'd47
  } op_e;

  typedef enum logic [2:0] {
    TRAP_NONE = 3'd0, TRAP_BOUNDS = 3'd1, TRAP_NIL = 3'd2, TRAP_DIVZERO = 3'd3,
    TRAP_DIVCHECK = 3'd4, TRAP_STACK = 3'd5, TRAP_SHIFT = 3'd6
  } trap_e;

  typedef struct packed {
    logic [5:0]  func;
    logic [7:0]  code_byte;
    logic [15:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  trap_code;
    logic [15:0] top_word;
    logic [15:0] second_word;
    logic [3:0]  depth;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture item and operands
    logic step;     // one iteration of multiply/divide
    logic finish;   // write back, build result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic iterate;  // item needs the iterative unit
    logic done;     // last iteration taken
  } dp_sts_t;

endpackage

// ===== sv/sma_ctrl.sv =====
// ============================================================================
// sma_ctrl
// Sequencer: accept an item, run the datapath, present the result.
// ============================================================================
module sma_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sma_pkg::dp_cmd_t cmd_o,
  input  sma_pkg::dp_sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_DECODE = 4'b0010, ST_ITER = 4'b0100, ST_WB = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Accept a new item while idle; the output register holds the last result
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    cmd_o        = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = sts_i.iterate ? ST_ITER : ST_WB;
      end
      ST_ITER: begin
        cmd_o.step = 1'b1;
        if (sts_i.done) state_d = ST_WB;
      end
      ST_WB: begin
        // Wait for the previous result to drain before writing the new one
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/sma_dp.sv =====
// ============================================================================
// sma_dp
// Stack datapath: stack registers, operand fetch, combinational ALU and a
// shared bit-serial multiply/divide unit.
// ============================================================================
module sma_dp #(
  parameter int unsigned StackDepth = sma_pkg::StackDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sma_pkg::in_item_t in_item_i,
  input  sma_pkg::dp_cmd_t  cmd_i,
  output sma_pkg::dp_sts_t  sts_o,
  output sma_pkg::out_item_t out_item_o
);

  localparam int unsigned SpW = 4;

  logic [15:0]    stk_q [StackDepth];
  logic [SpW-1:0] sp_q;
  logic [5:0]     func_q;
  logic [7:0]     byte_q;
  logic [15:0]    lit_q;
  logic [15:0]    w_q [4];   // words at sp-1 .. sp-4
  sma_pkg::out_item_t res_q;

  // Iterative unit registers
  logic [63:0] acc_q;        // multiply: product / divide: {rem, quot}
  logic [31:0] opa_q, opb_q; // multiplicand or divisor
  logic [5:0]  cnt_q;
  logic        neg_q_q, neg_r_q;

  // ---- Fetch top four words at load ----
  function automatic logic [15:0] rd(input logic [15:0] s [StackDepth],
                                     input logic [SpW-1:0] p, input int unsigned k);
    logic [SpW:0] idx;
    begin
      idx = {1'b0, p} - (SpW+1)'(k) - (SpW+1)'(1);
      rd = '0;
      for (int i = 0; i < StackDepth; i++) if (idx == (SpW+1)'(i)) rd = s[i];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_item_i.func;
      byte_q <= in_item_i.code_byte;
      lit_q  <= in_item_i.push_value;
      for (int k = 0; k < 4; k++) w_q[k] <= rd(stk_q, sp_q, k);
    end
  end

  // Operand views
  logic [15:0] w0, w1;
  logic [31:0] l0, l1;
  assign w0 = w_q[0];
  assign w1 = w_q[1];
  assign l0 = {w_q[0], w_q[1]};
  assign l1 = {w_q[2], w_q[3]};
  logic [5:0] op;
  assign op = func_q;

  // ---- Decode: pops, pushes and operands per opcode ----
  logic [2:0] npop, npush;
  logic       is_mul, is_div, is_rec;
  logic [31:0] mul_a, mul_b, div_a, div_b;
  logic        div_signed;

  always_comb begin
    npop = '0; npush = '0; is_mul = 1'b0; is_div = 1'b0; is_rec = 1'b0;
    mul_a = '0; mul_b = '0; div_a = '0; div_b = '0;
    div_signed = 1'b0;
    case (op)
      sma_pkg::OP_REC: begin npush = 3'd1; is_rec = 1'b1; end
      sma_pkg::OP_REC2: begin npush = 3'd2; is_rec = 1'b1; end
      sma_pkg::OP_DIS: npop = 3'd1;
      sma_pkg::OP_DIS2: npop = 3'd2;
      sma_pkg::OP_EXCH, sma_pkg::OP_BNDCK, sma_pkg::OP_AND, sma_pkg::OP_IOR,
      sma_pkg::OP_XOR, sma_pkg::OP_SHIFT, sma_pkg::OP_ROTATE, sma_pkg::OP_ADD,
      sma_pkg::OP_SUB: begin
        npop = 3'd2;
        npush = (op == sma_pkg::OP_EXCH) ? 3'd2 : 3'd1;
      end
      sma_pkg::OP_DEXCH: begin npop = 3'd4; npush = 3'd4; end
      sma_pkg::OP_DUP: begin npop = 3'd1; npush = 3'd2; end
      sma_pkg::OP_DDUP: begin npop = 3'd2; npush = 3'd4; end
      sma_pkg::OP_EXDIS: begin npop = 3'd2; npush = 3'd1; end
      sma_pkg::OP_BNDCKL, sma_pkg::OP_DAND, sma_pkg::OP_DIOR, sma_pkg::OP_DXOR,
      sma_pkg::OP_DADD, sma_pkg::OP_DSUB: begin npop = 3'd4; npush = 3'd2; end
      sma_pkg::OP_NILCK, sma_pkg::OP_NEG, sma_pkg::OP_INC, sma_pkg::OP_DEC,
      sma_pkg::OP_ADDSB, sma_pkg::OP_DBL, sma_pkg::OP_TRPL, sma_pkg::OP_SHIFTSB: begin
        npop = 3'd1; npush = 3'd1;
      end
      sma_pkg::OP_NILCKL, sma_pkg::OP_DINC, sma_pkg::OP_DDBL: begin
        npop = 3'd2; npush = 3'd2;
      end
      sma_pkg::OP_LINT: begin npop = 3'd1; npush = 3'd2; end
      sma_pkg::OP_DSHIFT, sma_pkg::OP_ADC, sma_pkg::OP_ACD: begin
        npop = 3'd3; npush = 3'd2;
      end
      sma_pkg::OP_MUL: begin
        npop = 3'd2; npush = 3'd1; is_mul = 1'b1;
        mul_a = {16'd0, w1}; mul_b = {16'd0, w0};
      end
      sma_pkg::OP_DMUL: begin
        npop = 3'd4; npush = 3'd2; is_mul = 1'b1; mul_a = l1; mul_b = l0;
      end
      sma_pkg::OP_SDIV, sma_pkg::OP_UDIV: begin
        npop = 3'd2; npush = 3'd1; is_div = 1'b1;
        div_signed = (op == sma_pkg::OP_SDIV);
        div_a = div_signed ? {{16{w1[15]}}, w1} : {16'd0, w1};
        div_b = div_signed ? {{16{w0[15]}}, w0} : {16'd0, w0};
      end
      sma_pkg::OP_LUDIV: begin
        npop = 3'd3; npush = 3'd1; is_div = 1'b1;
        div_a = {w_q[1], w_q[2]}; div_b = {16'd0, w0};
      end
      sma_pkg::OP_SDDIV, sma_pkg::OP_UDDIV: begin
        npop = 3'd4; npush = 3'd2; is_div = 1'b1;
        div_signed = (op == sma_pkg::OP_SDDIV); div_a = l1; div_b = l0;
      end
      sma_pkg::OP_DCMP, sma_pkg::OP_UDCMP: begin npop = 3'd4; npush = 3'd1; end
      sma_pkg::OP_PUSH: npush = 3'd1;
      default: ;
    endcase
  end

  // ---- Trap detection ----
  logic        stk_err;
  logic [15:0] sb16;
  logic signed [7:0] sb;
  logic [2:0]  trap;
  logic        div_zero;
  logic [SpW:0] sp_after;

  assign sb     = signed'(byte_q);
  assign sb16   = {{8{byte_q[7]}}, byte_q};
  assign stk_err = ({1'b0, sp_q} < (SpW+1)'(npop)) ||
                   (({1'b0, sp_q} - (SpW+1)'(npop) + (SpW+1)'(npush)) >
                    (SpW+1)'(StackDepth));
  assign div_zero = (div_b == 32'd0);
  assign sp_after = {1'b0, sp_q} - (SpW+1)'(npop) + (SpW+1)'(npush);

  always_comb begin
    trap = sma_pkg::TRAP_NONE;
    if (stk_err) trap = sma_pkg::TRAP_STACK;
    else if (op == sma_pkg::OP_BNDCK && w1 >= w0) trap = sma_pkg::TRAP_BOUNDS;
    else if (op == sma_pkg::OP_BNDCKL && l1 >= l0) trap = sma_pkg::TRAP_BOUNDS;
    else if (op == sma_pkg::OP_NILCK && w0 == 16'd0) trap = sma_pkg::TRAP_NIL;
    else if (op == sma_pkg::OP_NILCKL && l0 == 32'd0) trap = sma_pkg::TRAP_NIL;
    else if (op == sma_pkg::OP_SHIFTSB && (sb < -8'sd15 || sb > 8'sd15))
      trap = sma_pkg::TRAP_SHIFT;
    else if (is_div && div_zero) trap = sma_pkg::TRAP_DIVZERO;
    else if (op == sma_pkg::OP_LUDIV && w_q[1] >= w0) trap = sma_pkg::TRAP_DIVCHECK;
  end

  // ---- Combinational ALU helpers ----
  function automatic logic [15:0] sh16(input logic [15:0] u, input logic [15:0] c);
    begin
      if (!c[15] && c <= 16'd15) sh16 = u << c[3:0];
      else if (c[15] && c >= 16'hFFF1) sh16 = u >> (4'(~c[3:0]) + 4'd1);
      else sh16 = '0;
    end
  endfunction

  function automatic logic [31:0] sh32(input logic [31:0] u, input logic [15:0] c);
    logic [15:0] n;
    begin
      n = 16'd0 - c;
      if (!c[15] && c <= 16'd31) sh32 = u << c[4:0];
      else if (c[15] && c >= 16'hFFE1) sh32 = u >> n[4:0];
      else sh32 = '0;
    end
  endfunction

  function automatic logic [15:0] cmpc(input logic lt, input logic gt);
    cmpc = gt ? 16'd1 : (lt ? 16'hFFFF : 16'd0);
  endfunction

  // ---- Iterative multiply (shift-add) and divide (restoring) ----
  logic [32:0] dsub;
  logic [31:0] div_a_mag, div_b_mag;
  assign div_a_mag = (div_signed && div_a[31]) ? 32'd0 - div_a : div_a;
  assign div_b_mag = (div_signed && div_b[31]) ? 32'd0 - div_b : div_b;
  // Shifted partial remainder is 33 bits wide once the divisor exceeds 2^31
  assign dsub = acc_q[63:31] - {1'b0, opb_q};

  logic first_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) first_q <= 1'b0;
    else first_q <= cmd_i.load;
  end

  always_ff @(posedge clk_i) begin
    if (first_q) begin
      cnt_q   <= 6'd0;
      neg_q_q <= div_signed && (div_a[31] ^ div_b[31]);
      neg_r_q <= div_signed && div_a[31];
      if (is_mul) begin
        acc_q <= {32'd0, mul_b}; opa_q <= mul_a;
      end else begin
        acc_q <= {32'd0, div_a_mag}; opb_q <= div_b_mag;
      end
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + 6'd1;
      if (is_mul) begin
        // add-and-shift on the low multiplier bit
        acc_q <= {({1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, opa_q} : 33'd0)),
                  acc_q[31:1]};
      end else if (!dsub[32]) begin
        acc_q <= {dsub[31:0], acc_q[30:0], 1'b1};
      end else begin
        acc_q <= {acc_q[62:0], 1'b0};
      end
    end
  end

  assign sts_o.iterate = (is_mul || is_div) && (trap == sma_pkg::TRAP_NONE);
  assign sts_o.done    = (cnt_q == 6'd31);

  logic [31:0] quot, remd;
  assign quot = neg_q_q ? 32'd0 - acc_q[31:0] : acc_q[31:0];
  assign remd = neg_r_q ? 32'd0 - acc_q[63:32] : acc_q[63:32];

  // ---- Pushed words (p[0] pushed first) ----
  logic [15:0] p [4];
  logic [31:0] lr;
  always_comb begin
    for (int k = 0; k < 4; k++) p[k] = '0;
    lr = '0;
    case (op)
      sma_pkg::OP_EXCH: begin p[0] = w0; p[1] = w1; end
      sma_pkg::OP_DEXCH: begin p[0] = w_q[1]; p[1] = w_q[0]; p[2] = w_q[3]; p[3] = w_q[2]; end
      sma_pkg::OP_DUP: begin p[0] = w0; p[1] = w0; end
      sma_pkg::OP_DDUP: begin p[0] = w_q[1]; p[1] = w0; p[2] = w_q[1]; p[3] = w0; end
      sma_pkg::OP_EXDIS, sma_pkg::OP_NILCK: p[0] = w0;
      sma_pkg::OP_BNDCK: p[0] = w1;
      sma_pkg::OP_BNDCKL: begin p[0] = w_q[3]; p[1] = w_q[2]; end
      sma_pkg::OP_NILCKL: begin p[0] = w_q[1]; p[1] = w0; end
      sma_pkg::OP_NEG: p[0] = 16'd0 - w0;
      sma_pkg::OP_INC: p[0] = w0 + 16'd1;
      sma_pkg::OP_DEC: p[0] = w0 - 16'd1;
      sma_pkg::OP_ADDSB: p[0] = w0 + sb16;
      sma_pkg::OP_DBL: p[0] = {w0[14:0], 1'b0};
      sma_pkg::OP_TRPL: p[0] = w0 + {w0[14:0], 1'b0};
      sma_pkg::OP_LINT: begin p[0] = w0; p[1] = {16{w0[15]}}; end
      sma_pkg::OP_SHIFTSB: p[0] = sh16(w0, sb16);
      sma_pkg::OP_AND: p[0] = w1 & w0;
      sma_pkg::OP_IOR: p[0] = w1 | w0;
      sma_pkg::OP_XOR: p[0] = w1 ^ w0;
      sma_pkg::OP_SHIFT: p[0] = sh16(w1, w0);
      sma_pkg::OP_ROTATE: p[0] = (w1 << w0[3:0]) | (w1 >> (5'd16 - {1'b0, w0[3:0]}));
      sma_pkg::OP_ADD: p[0] = w1 + w0;
      sma_pkg::OP_SUB: p[0] = w1 - w0;
      sma_pkg::OP_MUL: p[0] = acc_q[15:0];
      sma_pkg::OP_SDIV, sma_pkg::OP_UDIV, sma_pkg::OP_LUDIV: begin
        p[0] = quot[15:0]; p[1] = remd[15:0];
      end
      sma_pkg::OP_DCMP: p[0] = cmpc(signed'(l1) < signed'(l0), signed'(l1) > signed'(l0));
      sma_pkg::OP_UDCMP: p[0] = cmpc(l1 < l0, l1 > l0);
      sma_pkg::OP_PUSH: p[0] = lit_q;
      default: begin
        case (op)
          sma_pkg::OP_DINC: lr = l0 + 32'd1;
          sma_pkg::OP_DDBL: lr = {l0[30:0], 1'b0};
          sma_pkg::OP_DAND: lr = l1 & l0;
          sma_pkg::OP_DIOR: lr = l1 | l0;
          sma_pkg::OP_DXOR: lr = l1 ^ l0;
          sma_pkg::OP_DSHIFT: lr = sh32({w_q[1], w_q[2]}, w0);
          sma_pkg::OP_DADD: lr = l1 + l0;
          sma_pkg::OP_DSUB: lr = l1 - l0;
          sma_pkg::OP_ADC: lr = {w_q[1], w_q[2]} + {16'd0, w0};
          sma_pkg::OP_ACD: lr = l0 + {16'd0, w_q[2]};
          sma_pkg::OP_DMUL: lr = acc_q[31:0];
          default: lr = '0;
        endcase
        p[0] = lr[15:0]; p[1] = lr[31:16];
        if (op == sma_pkg::OP_SDDIV || op == sma_pkg::OP_UDDIV) begin
          p[0] = quot[15:0]; p[1] = quot[31:16]; p[2] = remd[15:0]; p[3] = remd[31:16];
        end
      end
    endcase
    if (op == sma_pkg::OP_MUL) p[1] = acc_q[31:16];
  end

  // Words written above the new top (remainders, high product) stay recoverable
  logic [2:0] nwrite;
  always_comb begin
    nwrite = is_rec ? 3'd0 : npush;
    if (op == sma_pkg::OP_MUL || op == sma_pkg::OP_SDIV || op == sma_pkg::OP_UDIV ||
        op == sma_pkg::OP_LUDIV) nwrite = 3'd2;
    if (op == sma_pkg::OP_SDDIV || op == sma_pkg::OP_UDDIV) nwrite = 3'd4;
  end

  // ---- Write back ----
  logic [SpW:0] base;
  assign base = {1'b0, sp_q} - (SpW+1)'(npop);

  function automatic logic [15:0] top_at(input logic [15:0] s [StackDepth],
                                         input logic [SpW:0] d, input int unsigned k);
    begin
      top_at = '0;
      for (int i = 0; i < StackDepth; i++)
        if ((d > (SpW+1)'(k)) && (d - (SpW+1)'(k) - (SpW+1)'(1) == (SpW+1)'(i)))
          top_at = s[i];
    end
  endfunction

  logic [15:0] stk_n [StackDepth];
  always_comb begin
    for (int i = 0; i < StackDepth; i++) begin
      stk_n[i] = stk_q[i];
      for (int k = 0; k < 4; k++)
        if (3'(k) < nwrite && base + (SpW+1)'(k) == (SpW+1)'(i)) stk_n[i] = p[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
      for (int i = 0; i < StackDepth; i++) stk_q[i] <= '0;
    end else if (cmd_i.finish && trap == sma_pkg::TRAP_NONE) begin
      sp_q  <= sp_after[SpW-1:0];
      stk_q <= stk_n;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.trap_code <= trap;
      if (trap == sma_pkg::TRAP_NONE) begin
        res_q.top_word    <= top_at(stk_n, sp_after, 0);
        res_q.second_word <= top_at(stk_n, sp_after, 1);
        res_q.depth       <= sp_after[SpW-1:0];
      end else begin
        res_q.top_word    <= top_at(stk_q, {1'b0, sp_q}, 0);
        res_q.second_word <= top_at(stk_q, {1'b0, sp_q}, 1);
        res_q.depth       <= sp_q;
      end
    end
  end

  assign out_item_o = res_q;

endmodule

// ===== sv/stack_machine_alu_top.sv =====
// ============================================================================
// stack_machine_alu_top
// Evaluation stack ALU: one stack instruction per item, one result per item.
// ============================================================================
// One item at a time, accepted only while the block is idle. Most instructions
// pass from decode straight to write-back, where their result is registered,
// and the input is freed once write-back is done. Multiply and divide first
// run the bit-serial multiply/divide unit, one bit per cycle, between decode
// and write-back. A result still waiting for out_ready_i holds the next one in
// write-back until it is taken.
module stack_machine_alu_top #(
  parameter int unsigned StackDepth = sma_pkg::StackDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sma_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sma_pkg::out_item_t out_item_o
);

  sma_pkg::dp_cmd_t cmd;
  sma_pkg::dp_sts_t sts;

  sma_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  sma_dp #(.StackDepth(StackDepth)) u_dp (
    .clk_i, .rst_ni, .in_item_i, .cmd_i(cmd), .sts_o(sts), .out_item_o
  );

endmodule

// ===== sv/sma_checker.sv =====
// ============================================================================
// sma_checker
// Port-level checks on the stack ALU.
// ============================================================================
module sma_checker #(
  parameter int unsigned StackDepth = sma_pkg::StackDepthDefault
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input sma_pkg::out_item_t out_item_o
);

  // One item at a time: in_ready_o drops once an item is accepted
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("item accepted while busy");

  // Result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("result dropped while stalled");

  // Depth never above the stack size
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.depth <= 4'(StackDepth)))
    else $error("bad depth");

  // Trap codes are in range
  a_trap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.trap_code != 3'd7))
    else $error("bad trap code");

endmodule

bind stack_machine_alu_top sma_checker #(.StackDepth(StackDepth)) u_sma_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_item_o
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the evaluation stack ALU. A queue of instruction
// items feeds a clocked driver; a clocked monitor compares each result with
// the prediction of an in-bench stack model, in order, field by field.
// ============================================================================
module tb_top;
  import sma_pkg::*;

  localparam int Depth = 14;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;

  stack_machine_alu_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
  );

  always #10 clk_i = ~clk_i;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  bit stim_done = 1'b0;

  // Stack model state
  logic [15:0] mdl_words[Depth];
  int unsigned mdl_sp;
  trap_e       mdl_trap;

  function automatic void set_trap(trap_e t);
    if (mdl_trap == TRAP_NONE) mdl_trap = t;
  endfunction

  function automatic void push_word(logic [31:0] v);
    if (mdl_trap != TRAP_NONE) return;
    if (mdl_sp >= Depth) begin set_trap(TRAP_STACK); return; end
    mdl_words[mdl_sp] = v[15:0];
    mdl_sp++;
  endfunction

  function automatic logic [31:0] pop_word();
    if (mdl_trap != TRAP_NONE) return 0;
    if (mdl_sp == 0) begin set_trap(TRAP_STACK); return 0; end
    mdl_sp--;
    return {16'h0, mdl_words[mdl_sp]};
  endfunction

  function automatic void recover_word();
    if (mdl_trap != TRAP_NONE) return;
    if (mdl_sp >= Depth) begin set_trap(TRAP_STACK); return; end
    mdl_sp++;
  endfunction

  function automatic void push_long(logic [31:0] v);
    push_word({16'h0, v[15:0]});
    push_word({16'h0, v[31:16]});
  endfunction

  function automatic logic [31:0] pop_long();
    logic [31:0] hi, lo;
    hi = pop_word();
    lo = pop_word();
    return {hi[15:0], lo[15:0]};
  endfunction

  function automatic logic [31:0] shift_word(logic [31:0] u, int c);
    if (c >= 0 && c <= 15) return {16'h0, u[15:0] << c};
    if (c < 0 && c >= -15) return {16'h0, u[15:0] >> (-c)};
    return 0;
  endfunction

  function automatic logic [31:0] shift_long(logic [31:0] u, int c);
    if (c >= 0 && c <= 31) return u << c;
    if (c < 0 && c >= -31) return u >> (-c);
    return 0;
  endfunction

  function automatic logic [31:0] rotate_word(logic [31:0] u, int c);
    int n;
    logic [31:0] w;
    n = c & 15;
    w = {16'h0, u[15:0]};
    if (n == 0) return w;
    return ((w << n) | (w >> (16 - n))) & 32'hFFFF;
  endfunction

  function automatic logic [31:0] compare_code(bit lt, bit gt);
    return gt ? 32'd1 : (lt ? 32'hFFFF : 32'd0);
  endfunction

  // Execute one instruction on the model and return the expected result
  function automatic out_item_t execute_instr(in_item_t it);
    logic [15:0] saved[Depth];
    int unsigned saved_sp;
    logic [31:0] a, b;
    longint j, k;
    int sb;
    out_item_t r;
    saved = mdl_words;
    saved_sp = mdl_sp;
    mdl_trap = TRAP_NONE;
    sb = $signed(it.code_byte);
    case (it.func)
      OP_REC: recover_word();
      OP_REC2: begin recover_word(); recover_word(); end
      OP_DIS: void'(pop_word());
      OP_DIS2: begin void'(pop_word()); void'(pop_word()); end
      OP_EXCH: begin b = pop_word(); a = pop_word(); push_word(b); push_word(a); end
      OP_DEXCH: begin b = pop_long(); a = pop_long(); push_long(b); push_long(a); end
      OP_DUP: begin a = pop_word(); push_word(a); push_word(a); end
      OP_DDUP: begin a = pop_long(); push_long(a); push_long(a); end
      OP_EXDIS: begin a = pop_word(); void'(pop_word()); push_word(a); end
      OP_BNDCK: begin
        b = pop_word(); a = pop_word(); push_word(a);
        if (a >= b) set_trap(TRAP_BOUNDS);
      end
      OP_BNDCKL: begin
        b = pop_long(); a = pop_long(); push_long(a);
        if (a >= b) set_trap(TRAP_BOUNDS);
      end
      OP_NILCK: begin a = pop_word(); push_word(a); if (a == 0) set_trap(TRAP_NIL); end
      OP_NILCKL: begin a = pop_long(); push_long(a); if (a == 0) set_trap(TRAP_NIL); end
      OP_NEG: begin a = pop_word(); push_word(-a); end
      OP_INC: begin a = pop_word(); push_word(a + 1); end
      OP_DINC: begin a = pop_long(); push_long(a + 1); end
      OP_DEC: begin a = pop_word(); push_word(a - 1); end
      OP_ADDSB: begin a = pop_word(); push_word(a + sb); end
      OP_DBL: begin a = pop_word(); push_word(shift_word(a, 1)); end
      OP_DDBL: begin a = pop_long(); push_long(shift_long(a, 1)); end
      OP_TRPL: begin a = pop_word(); push_word(a * 3); end
      OP_LINT: begin a = pop_word(); push_word(a); push_word(a[15] ? 32'hFFFF : 32'h0); end
      OP_SHIFTSB: begin
        a = pop_word();
        if (sb < -15 || sb > 15) set_trap(TRAP_SHIFT);
        push_word(shift_word(a, sb));
      end
      OP_AND: begin b = pop_word(); a = pop_word(); push_word(a & b); end
      OP_DAND: begin b = pop_long(); a = pop_long(); push_long(a & b); end
      OP_IOR: begin b = pop_word(); a = pop_word(); push_word(a | b); end
      OP_DIOR: begin b = pop_long(); a = pop_long(); push_long(a | b); end
      OP_XOR: begin b = pop_word(); a = pop_word(); push_word(a ^ b); end
      OP_DXOR: begin b = pop_long(); a = pop_long(); push_long(a ^ b); end
      OP_SHIFT: begin
        b = pop_word(); a = pop_word(); push_word(shift_word(a, $signed(b[15:0])));
      end
      OP_DSHIFT: begin
        b = pop_word(); a = pop_long(); push_long(shift_long(a, $signed(b[15:0])));
      end
      OP_ROTATE: begin
        b = pop_word(); a = pop_word(); push_word(rotate_word(a, $signed(b[15:0])));
      end
      OP_ADD: begin b = pop_word(); a = pop_word(); push_word(a + b); end
      OP_SUB: begin b = pop_word(); a = pop_word(); push_word(a - b); end
      OP_DADD: begin b = pop_long(); a = pop_long(); push_long(a + b); end
      OP_DSUB: begin b = pop_long(); a = pop_long(); push_long(a - b); end
      OP_ADC: begin b = pop_word(); a = pop_long(); push_long(a + b); end
      OP_ACD: begin b = pop_long(); a = pop_word(); push_long(a + b); end
      OP_MUL: begin
        b = pop_word(); a = pop_word(); push_long(a * b); void'(pop_word());
      end
      OP_DMUL: begin b = pop_long(); a = pop_long(); push_long(a * b); end
      OP_SDIV: begin
        b = pop_word(); a = pop_word();
        if (mdl_trap == TRAP_NONE && b == 0) set_trap(TRAP_DIVZERO);
        if (mdl_trap == TRAP_NONE) begin
          j = longint'($signed(a[15:0])); k = longint'($signed(b[15:0]));
          push_word(32'(j / k)); push_word(32'(j % k)); void'(pop_word());
        end
      end
      OP_UDIV: begin
        b = pop_word(); a = pop_word();
        if (mdl_trap == TRAP_NONE && b == 0) set_trap(TRAP_DIVZERO);
        if (mdl_trap == TRAP_NONE) begin
          push_word(a / b); push_word(a % b); void'(pop_word());
        end
      end
      OP_LUDIV: begin
        b = pop_word(); a = pop_long();
        if (mdl_trap == TRAP_NONE && b == 0) set_trap(TRAP_DIVZERO);
        if (mdl_trap == TRAP_NONE && (a >> 16) >= b) set_trap(TRAP_DIVCHECK);
        if (mdl_trap == TRAP_NONE) begin
          push_word(a / b); push_word(a % b); void'(pop_word());
        end
      end
      OP_SDDIV: begin
        b = pop_long(); a = pop_long();
        if (mdl_trap == TRAP_NONE && b == 0) set_trap(TRAP_DIVZERO);
        if (mdl_trap == TRAP_NONE) begin
          j = longint'($signed(a)); k = longint'($signed(b));
          push_long(32'(j / k)); push_long(32'(j % k));
          void'(pop_word()); void'(pop_word());
        end
      end
      OP_UDDIV: begin
        b = pop_long(); a = pop_long();
        if (mdl_trap == TRAP_NONE && b == 0) set_trap(TRAP_DIVZERO);
        if (mdl_trap == TRAP_NONE) begin
          push_long(a / b); push_long(a % b); void'(pop_word()); void'(pop_word());
        end
      end
      OP_DCMP: begin
        b = pop_long(); a = pop_long();
        push_word(compare_code($signed(a) < $signed(b), $signed(a) > $signed(b)));
      end
      OP_UDCMP: begin
        b = pop_long(); a = pop_long(); push_word(compare_code(a < b, a > b));
      end
      OP_PUSH: push_word({16'h0, it.push_value});
      default: ;
    endcase
    if (mdl_trap != TRAP_NONE) begin
      mdl_words = saved;
      mdl_sp = saved_sp;
    end
    r.trap_code = mdl_trap;
    r.top_word = (mdl_sp >= 1) ? mdl_words[mdl_sp-1] : 16'h0;
    r.second_word = (mdl_sp >= 2) ? mdl_words[mdl_sp-2] : 16'h0;
    r.depth = mdl_sp[3:0];
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'($urandom_range(0, 3));
      4: return 16'hFFFF - 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($signed($urandom_range(0, 30)) - 15);
  endfunction

  function automatic in_item_t make_item(logic [5:0] f, logic [7:0] cb, logic [15:0] pv);
    in_item_t it;
    it.func = f;
    it.code_byte = cb;
    it.push_value = pv;
    return it;
  endfunction

  // Fill the item queue: directed opening, then random stimulus
  initial begin
    int n;
    logic [5:0] f;
    pending_items.push_back(make_item(OP_DIS, 8'h00, 16'h0));       // underflow
    pending_items.push_back(make_item(OP_ADD, 8'h00, 16'h0));
    pending_items.push_back(make_item(OP_PUSH, 8'h00, 16'h8000));
    pending_items.push_back(make_item(OP_PUSH, 8'h00, 16'hFFFF));
    pending_items.push_back(make_item(OP_SDIV, 8'h00, 16'h0));      // min / -1
    pending_items.push_back(make_item(OP_REC, 8'h00, 16'h0));
    pending_items.push_back(make_item(OP_PUSH, 8'h00, 16'h0));
    pending_items.push_back(make_item(OP_UDIV, 8'h00, 16'h0));      // divide by zero
    pending_items.push_back(make_item(OP_SHIFTSB, 8'h10, 16'h0));   // bad shift
    pending_items.push_back(make_item(OP_SHIFTSB, 8'hF1, 16'h0));
    pending_items.push_back(make_item(OP_ADDSB, 8'h80, 16'h0));
    pending_items.push_back(make_item(OP_ADDSB, 8'h7F, 16'h0));
    pending_items.push_back(make_item(OP_NILCK, 8'h00, 16'h0));
    pending_items.push_back(make_item(OP_BNDCK, 8'h00, 16'h0));
    pending_items.push_back(make_item(6'd63, 8'hFF, 16'hFFFF));      // unused opcode
    for (int i = 0; i < 14; i++)                                   // fill then overflow
      pending_items.push_back(make_item(OP_PUSH, 8'h00, i[0] ? 16'hFFFF : 16'h0000));
    pending_items.push_back(make_item(OP_REC, 8'h00, 16'h0));
    for (int i = 0; i < 6; i++) pending_items.push_back(make_item(OP_DIS2, 8'h00, 16'h0));
    n = 0;
    while (n < 1700) begin
      if ($urandom_range(0, 9) < 4) begin
        // operand pushes keep the stack well populated
        pending_items.push_back(make_item(OP_PUSH, rand_byte(), rand_word()));
      end else begin
        f = ($urandom_range(0, 40) == 0) ? 6'($urandom_range(48, 63))
                                         : 6'($urandom_range(0, 46));
        pending_items.push_back(make_item(f, rand_byte(), 16'($urandom)));
      end
      n++;
    end
    stim_done = 1'b1;
  end

  // Reset
  initial begin
    for (int i = 0; i < Depth; i++) mdl_words[i] = 16'h0;
    mdl_sp = 0;
    mdl_trap = TRAP_NONE;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Note the handshakes taken at the last rising edge
  bit in_fire = 1'b0;
  bit out_fire = 1'b0;
  always @(posedge clk_i) begin
    in_fire  <= in_valid_i && in_ready_o;
    out_fire <= out_valid_o && out_ready_i;
  end

  // Driver: present items at the falling edge, hold until accepted
  int in_gap = 0;
  int out_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        // accepted at the last rising edge; predict its result
        expected_results.push_back(execute_instr(in_item_i));
        in_gap = gap_len();
        if (in_gap == 0 && pending_items.size() > 0) begin
          in_item_i <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end else if (!in_valid_i) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() > 0) begin
          in_item_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end
      end
      // Hold ready low for a random gap after each result taken
      if (out_fire) out_gap = gap_len();
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item_o);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.trap_code !== out_item_o.trap_code)
          $display("%0t: trap_code expected %0d actual %0d", $time, exp_r.trap_code,
                   out_item_o.trap_code);
        if (exp_r.top_word !== out_item_o.top_word)
          $display("%0t: top_word expected %h actual %h", $time, exp_r.top_word,
                   out_item_o.top_word);
        if (exp_r.second_word !== out_item_o.second_word)
          $display("%0t: second_word expected %h actual %h", $time, exp_r.second_word,
                   out_item_o.second_word);
        if (exp_r.depth !== out_item_o.depth)
          $display("%0t: depth expected %0d actual %0d", $time, exp_r.depth,
                   out_item_o.depth);
        if (exp_r !== out_item_o) errors++;
      end
    end
  end

  // End of run: drain, settle, report
  initial begin
    wait (stim_done && rst_ni);
    wait (pending_items.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/sma_pkg.sv
sv/sma_ctrl.sv
sv/sma_dp.sv
sv/stack_machine_alu_top.sv
sv/sma_checker.sv
test/tb_top.sv
